// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the quadrature decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define QD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qdec_pkg.sv =====
// Types, codes and constants of the quadrature decoder.
`default_nettype none

package qdec_pkg;

    // Input request: one edge event
    typedef struct packed {
        logic [7:0]  pin_number;
        logic        new_level;
        logic [31:0] edge_time;
    } t_in_item;

    // Result request: count, angle and timestamp
    typedef struct packed {
        logic signed [31:0] position_count;
        logic signed [47:0] angle_deg_q8;
        logic [31:0]        last_time;
    } t_out_item;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PIN_A = 2'd0;
    localparam t_cfg_idx CFG_PIN_B = 2'd1;
    localparam t_cfg_idx CFG_CPR   = 2'd2;

    localparam logic [7:0]  UNASSIGNED_PIN = 8'hFF;
    localparam logic [7:0]  PIN_RESET      = UNASSIGNED_PIN;
    localparam logic [15:0] CPR_RESET      = 16'd0;

    // Step decoded from {old A, old B, new A, new B}
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } t_step;

    localparam t_step STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Angle unit sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/quadrature_decoder_with_angle.sv =====
// Top level: x4 quadrature decoder with angle output, configuration registers.
// An event is accepted when the queue has room; its result is produced by the angle unit, whose
// bit-serial divider takes COUNT_WIDTH+17 steps, after a multiply step and before a done state.
// The angle unit handles one counted event at a time; a two-entry queue absorbs bursts.
// Unmatched-pin events are dropped at one per cycle while the queue has room; they give no result.
// Reset (i_rst_n low, synchronous): levels and count to 0, pins to 255, cpr to 0, queue empty.
`default_nettype none

module quadrature_decoder_with_angle
    import qdec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out_item   o_out_item,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int QDATA_W = COUNT_WIDTH + 32;

    logic [7:0]         r_pin_a, r_pin_b;
    logic [15:0]        r_cpr;
    logic               push, pop;
    logic [QDATA_W-1:0] push_data, pop_data;
    t_q_status          q_status;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_a <= PIN_RESET;
            r_pin_b <= PIN_RESET;
            r_cpr   <= CPR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PIN_A: r_pin_a <= i_cfg_data[7:0];
                CFG_PIN_B: r_pin_b <= i_cfg_data[7:0];
                CFG_CPR:   r_cpr   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    qdec_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .i_pin_a     (r_pin_a),
        .i_pin_b     (r_pin_b),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    qdec_fifo #(
        .DATA_W (QDATA_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_data),
        .i_pop    (pop),
        .o_data   (pop_data),
        .o_status (q_status)
    );

    qdec_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (pop_data),
        .o_pop      (pop),
        .i_cpr      (r_cpr),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/qdec_front.sv =====
// Front end: pin matching, x4 step decode and position count.
`default_nettype none

module qdec_front
    import qdec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  t_in_item                     i_item,
    input  wire  [7:0]                   i_pin_a,
    input  wire  [7:0]                   i_pin_b,
    input  t_q_status                    i_q_status,
    output logic                         o_push,
    output logic [COUNT_WIDTH+32-1:0]    o_push_data
);

    logic                   r_level_a, r_level_b;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   n_level_a, n_level_b;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   a_hit, b_hit, accept;
    logic [3:0]             step_idx;
    t_step                  step;

    // Room in the queue is all the front needs
    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // Channel A wins when both channels share a pin
    assign a_hit = (i_pin_a != UNASSIGNED_PIN) && (i_item.pin_number == i_pin_a);
    assign b_hit = !a_hit && (i_pin_b != UNASSIGNED_PIN) && (i_item.pin_number == i_pin_b);

    // New levels and step decode
    always_comb begin
        n_level_a = a_hit ? i_item.new_level : r_level_a;
        n_level_b = b_hit ? i_item.new_level : r_level_b;
        step_idx  = {r_level_a, r_level_b, n_level_a, n_level_b};
        step      = STEP_TABLE[step_idx];
        unique case (step)
            STEP_UP:   n_count = r_count + COUNT_WIDTH'(1);
            STEP_DOWN: n_count = r_count - COUNT_WIDTH'(1);
            default:   n_count = r_count;
        endcase
    end

    assign o_push      = accept && (a_hit || b_hit);
    assign o_push_data = {n_count, i_item.edge_time};

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_a <= 1'b0;
            r_level_b <= 1'b0;
            r_count   <= '0;
        end else if (o_push) begin
            r_level_a <= n_level_a;
            r_level_b <= n_level_b;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qdec_fifo.sv =====
// Short queue of decoded events between front and back.
`default_nettype none
`include "assert_macros.svh"

module qdec_fifo
    import qdec_pkg::*;
#(
    parameter int DATA_W = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire  [DATA_W-1:0]   i_data,
    input  wire                 i_pop,
    output logic [DATA_W-1:0]   o_data,
    output t_q_status           o_status
);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_fill;

    assign o_status.full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_data         = r_mem[r_rd_ptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    `QD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_status.full, "push into full queue")
    `QD_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_status.empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== hw/rtl/qdec_back.sv =====
// Back end: angle = count*360*256/cpr by restoring division, saturation, output register.
`default_nettype none
`include "assert_macros.svh"

module qdec_back
    import qdec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_q_status                    i_q_status,
    input  wire  [COUNT_WIDTH+32-1:0]    i_q_data,
    output logic                         o_pop,
    input  wire  [15:0]                  i_cpr,
    output logic                         o_valid,
    input  wire                          i_ready,
    output t_out_item                    o_item
);

    // Quotient width: magnitude times 360*256 (17 bits)
    localparam int QW    = COUNT_WIDTH + 17;
    localparam int CNT_W = $clog2(QW);
    localparam int SW    = (QW > 49) ? QW : 49;
    localparam logic [SW-1:0] POS_MAX = SW'({1'b0, {47{1'b1}}});
    localparam logic [SW-1:0] NEG_MAG = SW'({1'b1, {47{1'b0}}});

    t_back_state            r_state, n_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [31:0]            r_time;
    logic                   r_neg, r_zero;
    logic [QW-1:0]          r_num;
    logic [15:0]            r_rem;
    logic [15:0]            r_cpr;
    logic [CNT_W-1:0]       r_bit_cnt;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   out_free, load, mul_en, div_en;
    logic [COUNT_WIDTH-1:0] mag;
    logic [QW-1:0]          mag_ext, product;
    logic [16:0]            rem_sh;
    logic                   rem_ge;
    logic [16:0]            rem_sub;
    logic [SW-1:0]          q_ext;
    logic [47:0]            sat_mag, angle;
    logic [63:0]            count_ext;

    assign out_free = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_q_status.empty) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (r_bit_cnt == '0) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop  = 1'b0;
        mul_en = 1'b0;
        div_en = 1'b0;
        load   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop  = !i_q_status.empty;
            ST_MUL:  mul_en = 1'b1;
            ST_DIV:  div_en = 1'b1;
            ST_DONE: load   = out_free;
            default: ;
        endcase
    end

    // Magnitude times 92160 = 360*256 = (2^8+2^6+2^5+2^3)*2^8
    always_comb begin
        mag     = r_neg ? (~r_count + COUNT_WIDTH'(1)) : r_count;
        mag_ext = QW'(mag);
        product = (mag_ext << 16) + (mag_ext << 14) + (mag_ext << 13) + (mag_ext << 11);
    end

    // One restoring division step
    always_comb begin
        rem_sh  = {r_rem, r_num[QW-1]};
        rem_ge  = (rem_sh >= {1'b0, r_cpr});
        rem_sub = rem_sh - {1'b0, r_cpr};
    end

    // Saturate the quotient and apply sign
    always_comb begin
        q_ext = SW'(r_num);
        if (r_neg) begin
            sat_mag = (q_ext > NEG_MAG) ? NEG_MAG[47:0] : q_ext[47:0];
            angle   = ~sat_mag + 48'd1;
        end else begin
            sat_mag = (q_ext > POS_MAX) ? POS_MAX[47:0] : q_ext[47:0];
            angle   = sat_mag;
        end
        if (r_zero) begin
            angle = '0;
        end
        count_ext = 64'(r_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_count <= i_q_data[COUNT_WIDTH+32-1:32];
            r_time  <= i_q_data[31:0];
            r_neg   <= i_q_data[COUNT_WIDTH+32-1];
            r_zero  <= (i_cpr == '0);
            r_cpr   <= i_cpr;
        end
        if (mul_en) begin
            r_num     <= product;
            r_rem     <= '0;
            r_bit_cnt <= CNT_W'(QW-1);
        end
        if (div_en) begin
            r_num     <= {r_num[QW-2:0], rem_ge};
            r_rem     <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end
        if (load) begin
            r_out_item.position_count <= count_ext[31:0];
            r_out_item.angle_deg_q8   <= angle;
            r_out_item.last_time      <= r_time;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `QD_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_state == ST_MUL, "pop did not start multiply")
    `QD_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, (r_state == ST_DIV) && (r_bit_cnt == '0), r_state == ST_DONE, "division did not finish")

endmodule

`default_nettype wire
